[design/pidda_pkg.sv]
// Shared constants, types and register indexes of the PID controller.
package pidda_pkg;

    // Field widths and fixed-point positions.
    localparam int DATA_W   = 32;
    localparam int DT_W     = 24;
    localparam int FRAC_W   = 16;
    localparam int DT_FRAC  = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = TERM_W + 2;
    localparam int ACCW_W   = TERM_W + 1;
    localparam int NUM_W    = DATA_W + 1 + DT_FRAC;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRV_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRV_HI = 3'd7;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_P,
        S_EDT,
        S_CLAMP,
        S_ISTART,
        S_I,
        S_DIV,
        S_DSTART,
        S_D,
        S_SUM,
        S_SAT,
        S_CLIP,
        S_OUT
    } t_state;

endpackage

[design/pidda_mul.sv]
// Bit-serial signed multiplier, one multiplier bit per cycle.
module pidda_mul import pidda_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_hi;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_mcand;
    logic              r_neg;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DATA_W:0]   sum;
    logic [PROD_W-1:0] mag_prod;

    // Operand magnitudes; the most negative value maps to its own bit pattern.
    assign a_mag = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign b_mag = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;

    // Add the multiplicand when the low multiplier bit is set.
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(DATA_W+1){1'b0}});

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Product shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi    <= '0;
            r_lo    <= b_mag;
            r_mcand <= a_mag;
            r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
        end else if (r_busy) begin
            r_hi <= sum[DATA_W:1];
            r_lo <= {sum[0], r_lo[DATA_W-1:1]};
        end
    end

    assign mag_prod = {r_hi, r_lo};
    assign o_prod   = r_neg ? -$signed(mag_prod) : $signed(mag_prod);
    assign o_done   = r_done;

endmodule

[design/pidda_div.sv]
// Bit-serial restoring divider, truncating toward zero and saturating to 32 bits.
module pidda_div import pidda_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W:0]   i_num,
    input  logic [DT_W-1:0]          i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_nq;
    logic [DT_W-1:0]   r_rem;
    logic [DT_W-1:0]   r_den;
    logic              r_neg;
    logic [DATA_W:0]   num_mag;
    logic [DT_W:0]     rs;
    logic [DT_W:0]     rdiff;
    logic              ge;
    logic              big_pos;
    logic              big_neg;
    logic [DATA_W-1:0] q_low;

    assign num_mag = i_num[DATA_W] ? (~i_num + 1'b1) : i_num;

    // One quotient bit per cycle.
    assign rs    = {r_rem, r_nq[NUM_W-1]};
    assign rdiff = rs - {1'b0, r_den};
    assign ge    = (rs >= {1'b0, r_den});

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Numerator and quotient share one shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= {num_mag, {DT_FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[DATA_W];
        end else if (r_busy) begin
            r_rem <= ge ? rdiff[DT_W-1:0] : rs[DT_W-1:0];
            r_nq  <= {r_nq[NUM_W-2:0], ge};
        end
    end

    // Apply the sign and saturate to the data width.
    assign q_low   = r_nq[DATA_W-1:0];
    assign big_pos = (r_nq[NUM_W-1:DATA_W-1] != '0);
    assign big_neg = (r_nq[NUM_W-1:DATA_W] != '0) ||
                     (r_nq[DATA_W-1] && (r_nq[DATA_W-2:0] != '0));

    always_comb begin
        if (r_neg) begin
            o_quot = big_neg ? $signed({1'b1, {(DATA_W-1){1'b0}}}) : -$signed(q_low);
        end else begin
            o_quot = big_pos ? $signed({1'b0, {(DATA_W-1){1'b1}}}) : $signed(q_low);
        end
    end

    assign o_done = r_done;

endmodule

[design/pid_controller_deadband_antiwindup.sv]
// Top level of the fixed-point PID controller with deadband and integral clamp.
//
// One word is taken at a time. A clear, a zero time step or an error inside
// the deadband goes from S_DECIDE straight to S_OUT with a zero result. A full
// sample runs four products on one bit-serial multiplier (kp*e, e*dt, ki*I,
// kd*D) plus a bit-serial divider for the derivative, then summing, saturation
// and clamping. The first sample after a clear or a reset skips the divider
// and the derivative product. A new word is accepted while the previous result
// still waits.
module pid_controller_deadband_antiwindup import pidda_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_cmd,
    input  logic signed [DATA_W-1:0] i_error_in,
    input  logic [DT_W-1:0]          i_step_time,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_drive_out
);

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_kp, r_ki, r_kd;
    logic [DATA_W-2:0]        r_dband;
    logic signed [DATA_W-1:0] r_acc_lo, r_acc_hi, r_drv_lo, r_drv_hi;
    logic signed [DATA_W-1:0] r_acc, r_last;
    logic                     r_first;
    logic                     r_cmd;
    logic signed [DATA_W-1:0] r_e;
    logic [DT_W-1:0]          r_dt;
    logic signed [DATA_W:0]   r_diff;
    logic signed [TERM_W-1:0] r_p, r_i, r_d;
    logic signed [ACCW_W-1:0] r_accw;
    logic signed [DATA_W-1:0] r_deriv;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DATA_W-1:0] r_sat;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;

    logic                     mul_start, mul_done;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     div_start, div_done;
    logic signed [DATA_W-1:0] div_quot;
    logic [DATA_W-1:0]        e_mag;
    logic                     skip;
    logic                     out_room;
    logic signed [ACCW_W-1:0] acc_lo_w, acc_hi_w, acc_t;
    logic signed [DATA_W-1:0] acc_clamped;
    logic signed [DATA_W-1:0] res_t;
    logic signed [TERM_W-1:0] prod_term;

    pidda_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pidda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_diff),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_dband  <= '0;
            r_acc_lo <= $signed({1'b1, {(DATA_W-1){1'b0}}});
            r_acc_hi <= $signed({1'b0, {(DATA_W-1){1'b1}}});
            r_drv_lo <= $signed({1'b1, {(DATA_W-1){1'b0}}});
            r_drv_hi <= $signed({1'b0, {(DATA_W-1){1'b1}}});
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KP:     r_kp     <= i_cfg_data;
                REG_KI:     r_ki     <= i_cfg_data;
                REG_KD:     r_kd     <= i_cfg_data;
                REG_DBAND:  r_dband  <= i_cfg_data[DATA_W-2:0];
                REG_ACC_LO: r_acc_lo <= i_cfg_data;
                REG_ACC_HI: r_acc_hi <= i_cfg_data;
                REG_DRV_LO: r_drv_lo <= i_cfg_data;
                REG_DRV_HI: r_drv_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero-output cases for a compute command.
    assign e_mag    = r_e[DATA_W-1] ? (~r_e + 1'b1) : r_e;
    assign skip     = (r_dt == '0) || (e_mag <= {1'b0, r_dband});
    assign out_room = !r_out_valid || !i_out_stall;

    // Product floored by the fraction bits.
    assign prod_term = mul_prod[PROD_W-1:FRAC_W];

    // Integral clamp: raise to the lower limit, then lower to the upper.
    assign acc_lo_w    = ACCW_W'(r_acc_lo);
    assign acc_hi_w    = ACCW_W'(r_acc_hi);
    assign acc_t       = (r_accw < acc_lo_w) ? acc_lo_w : r_accw;
    assign acc_clamped = (acc_t > acc_hi_w) ? r_acc_hi : acc_t[DATA_W-1:0];

    // Output clamp, in the same order.
    assign res_t = (r_sat < r_drv_lo) ? r_drv_lo : r_sat;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit starts.
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = r_kp;
        mul_b     = r_e;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_cmd || skip) begin
                    n_state = S_OUT;
                end else begin
                    mul_start = 1'b1;
                    n_state   = S_P;
                end
            end
            S_P: begin
                mul_a = r_e;
                mul_b = $signed({{(DATA_W-DT_W){1'b0}}, r_dt});
                if (mul_done) begin
                    mul_start = 1'b1;
                    n_state   = S_EDT;
                end
            end
            S_EDT: begin
                if (mul_done) n_state = S_CLAMP;
            end
            S_CLAMP: n_state = S_ISTART;
            S_ISTART: begin
                mul_a     = r_ki;
                mul_b     = r_acc;
                mul_start = 1'b1;
                n_state   = S_I;
            end
            S_I: begin
                if (mul_done) begin
                    if (r_first) begin
                        n_state = S_SUM;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_DSTART;
            end
            S_DSTART: begin
                mul_a     = r_kd;
                mul_b     = r_deriv;
                mul_start = 1'b1;
                n_state   = S_D;
            end
            S_D: begin
                if (mul_done) n_state = S_SUM;
            end
            S_SUM:  n_state = S_SAT;
            S_SAT:  n_state = S_CLIP;
            S_CLIP: n_state = S_OUT;
            S_OUT: begin
                if (out_room) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_last  <= '0;
            r_first <= 1'b1;
        end else begin
            if (r_state == S_DECIDE && r_cmd) begin
                r_acc   <= '0;
                r_last  <= '0;
                r_first <= 1'b1;
            end
            if (r_state == S_CLAMP) r_acc <= acc_clamped;
            if (r_state == S_I && mul_done) r_first <= 1'b0;
            if (r_state == S_SUM) r_last <= r_e;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= i_cmd;
            r_e   <= i_error_in;
            r_dt  <= i_step_time;
        end
        if (r_state == S_DECIDE) begin
            r_diff <= (DATA_W+1)'(r_e) - (DATA_W+1)'(r_last);
            r_d    <= '0;
            r_res  <= '0;
        end
        if (r_state == S_P && mul_done) r_p <= prod_term;
        if (r_state == S_EDT && mul_done) r_accw <= ACCW_W'(r_acc) + ACCW_W'(prod_term);
        if (r_state == S_I && mul_done) r_i <= prod_term;
        if (r_state == S_DIV && div_done) r_deriv <= div_quot;
        if (r_state == S_D && mul_done) r_d <= prod_term;
        if (r_state == S_SUM) r_sum <= SUM_W'(r_p) + SUM_W'(r_i) + SUM_W'(r_d);
        if (r_state == S_SAT) begin
            if (r_sum[SUM_W-1:DATA_W-1] == '0 || r_sum[SUM_W-1:DATA_W-1] == '1) begin
                r_sat <= r_sum[DATA_W-1:0];
            end else if (r_sum[SUM_W-1]) begin
                r_sat <= $signed({1'b1, {(DATA_W-1){1'b0}}});
            end else begin
                r_sat <= $signed({1'b0, {(DATA_W-1){1'b1}}});
            end
        end
        if (r_state == S_CLIP) r_res <= (res_t > r_drv_hi) ? r_drv_hi : res_t;
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_room) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_room) r_out_data <= r_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive_out = r_out_data;

`ifndef SYNTHESIS
    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_P || r_state == S_EDT || r_state == S_I ||
                      r_state == S_D))
        else $error("multiplier finished outside a product state");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // With ordered limits the integral lands inside them.
    a_acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && r_acc_lo <= r_acc_hi) |=>
        (r_acc >= $past(r_acc_lo) && r_acc <= $past(r_acc_hi)))
        else $error("integral outside its limits");

    // A clear leaves the integral and previous error at zero.
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_cmd) |=> (r_acc == '0 && r_last == '0 && r_first))
        else $error("clear did not reset the controller state");
`endif

endmodule

[tb/pid_controller_deadband_antiwindup_tb.sv]
// Self-checking testbench of the fixed-point PID controller with deadband and integral clamp.
`timescale 1ns / 1ps

module pid_controller_deadband_antiwindup_tb;
    import pidda_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = REG_KP;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_cmd = 1'b0;
    logic signed [DATA_W-1:0] i_error_in = '0;
    logic [DT_W-1:0]          i_step_time = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive_out;

    pid_controller_deadband_antiwindup dut (.*);

    // Clock with an 8 ns period.
    always #4 i_clk = ~i_clk;

    // Shadow copy of the registers and of the controller state.
    longint kp, ki, kd, dband, acc_lo, acc_hi, drv_lo, drv_hi;
    longint integ, prev_err;
    bit     first_smp;

    logic signed [DATA_W-1:0] drive_q[$];
    int unsigned n_errors = 0;
    int unsigned n_results = 0;
    bit          pressure_armed = 1'b1;
    int unsigned hold_cycles = 0;

    function automatic longint clamp(longint x, longint lo, longint hi);
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return x;
    endfunction

    function automatic longint sat32(longint x);
        return clamp(x, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // Expected drive for one word; updates the shadow state as the block does.
    function automatic logic signed [DATA_W-1:0] next_drive(logic c, logic signed [31:0] err,
                                                            logic [23:0] dt);
        longint e, t, mag, p, i, d, dv, sum;
        e = err;
        t = dt;
        if (c) begin
            integ = 0;
            prev_err = 0;
            first_smp = 1'b1;
            return '0;
        end
        mag = (e < 0) ? -e : e;
        if (t == 0 || mag <= dband) return '0;
        p = (kp * e) >>> FRAC_W;
        integ = clamp(integ + ((e * t) >>> DT_FRAC), acc_lo, acc_hi);
        i = (ki * integ) >>> FRAC_W;
        dv = 0;
        if (first_smp) first_smp = 1'b0;
        else dv = sat32(((e - prev_err) * 65536) / t);
        d = (kd * dv) >>> FRAC_W;
        prev_err = e;
        sum = clamp(sat32(p + i + d), drv_lo, drv_hi);
        return sum[31:0];
    endfunction

    // Writes all eight registers, one per cycle, and mirrors them.
    task automatic write_regs(input logic [31:0] v[8]);
        for (int r = 0; r < 8; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_data  <= v[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        kp = longint'(signed'(v[REG_KP]));
        ki = longint'(signed'(v[REG_KI]));
        kd = longint'(signed'(v[REG_KD]));
        dband = longint'({1'b0, v[REG_DBAND][30:0]});
        acc_lo = longint'(signed'(v[REG_ACC_LO]));
        acc_hi = longint'(signed'(v[REG_ACC_HI]));
        drv_lo = longint'(signed'(v[REG_DRV_LO]));
        drv_hi = longint'(signed'(v[REG_DRV_HI]));
    endtask

    // Waits until every expected drive has come back.
    task automatic wait_drained();
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Offers one word and holds it until the block takes it.
    task automatic offer(input logic c, input logic [31:0] err, input logic [23:0] dt);
        i_in_valid  <= 1'b1;
        i_cmd       <= c;
        i_error_in  <= err;
        i_step_time <= dt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Directed words; typed results only where they are obvious.
    typedef struct {
        logic        c;
        logic [31:0] err;
        logic [23:0] dt;
        bit          fixed;
        logic [31:0] drive;
    } t_row;

    t_row rows[] = '{
        '{1'b1, 32'h7fff_ffff, 24'hff_ffff, 1'b1, 32'h0},
        '{1'b0, 32'h7fff_ffff, 24'h00_0000, 1'b1, 32'h0},
        '{1'b0, 32'h0000_0080, 24'h01_0000, 1'b1, 32'h0},
        '{1'b0, 32'hffff_ff00, 24'h01_0000, 1'b1, 32'h0},
        '{1'b0, 32'h0000_0101, 24'hff_ffff, 1'b0, 32'h0},
        '{1'b0, 32'hffff_feff, 24'h00_0001, 1'b0, 32'h0},
        '{1'b0, 32'h7fff_ffff, 24'hff_ffff, 1'b0, 32'h0},
        '{1'b0, 32'h8000_0000, 24'h00_0001, 1'b0, 32'h0},
        '{1'b0, 32'h0001_0000, 24'h01_0000, 1'b0, 32'h0},
        '{1'b0, 32'hfffe_0000, 24'h00_8000, 1'b0, 32'h0},
        '{1'b0, 32'h7fff_ffff, 24'h00_0001, 1'b0, 32'h0},
        '{1'b0, 32'h8000_0000, 24'h00_0001, 1'b0, 32'h0},
        '{1'b1, 32'h0000_0000, 24'h00_0000, 1'b1, 32'h0},
        '{1'b0, 32'h8000_0000, 24'hff_ffff, 1'b0, 32'h0},
        '{1'b0, 32'h0000_5555, 24'h55_5555, 1'b0, 32'h0},
        '{1'b0, 32'hffff_aaaa, 24'haa_aaaa, 1'b0, 32'h0},
        '{1'b0, 32'h0000_0100, 24'h00_0003, 1'b1, 32'h0}
    };

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_error();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // Stimulus: reset, a zero-gain sample, directed table, then random phases with fresh settings.
    initial begin
        logic [31:0] cfg[8];
        logic [31:0] a, b;
        int unsigned burst, gap;
        logic        c;
        logic [31:0] err;
        logic [23:0] dt;
        logic [31:0] dv;

        kp = 0; ki = 0; kd = 0; dband = 0;
        acc_lo = -64'sd2147483648; acc_hi = 64'sd2147483647;
        drv_lo = -64'sd2147483648; drv_hi = 64'sd2147483647;
        integ = 0; prev_err = 0; first_smp = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A sample straight after reset: all gains are zero.
        offer(1'b0, 32'h1234_5678, 24'h00_1000);
        void'(next_drive(1'b0, 32'h1234_5678, 24'h00_1000));
        drive_q.push_back('0);
        i_in_valid <= 1'b0;
        wait_drained();

        cfg = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_0100,
                32'hfff0_0000, 32'h0010_0000, 32'h8000_0000, 32'h7fff_ffff};
        write_regs(cfg);
        foreach (rows[k]) begin
            offer(rows[k].c, rows[k].err, rows[k].dt);
            dv = next_drive(rows[k].c, rows[k].err, rows[k].dt);
            drive_q.push_back(rows[k].fixed ? rows[k].drive : dv);
            if ($urandom_range(0, 2) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < 9; ph++) begin
            wait_drained();
            for (int r = 0; r < 3; r++) cfg[r] = pick_gain();
            case ($urandom_range(0, 4))
                0: cfg[REG_DBAND] = 32'h0;
                1: cfg[REG_DBAND] = $urandom();
                default: cfg[REG_DBAND] = $urandom_range(0, 32'h0001_0000);
            endcase
            if (ph == 8) cfg[REG_DBAND] = 32'h7fff_ffff;
            for (int r = 4; r < 8; r += 2) begin
                a = $urandom();
                b = $urandom();
                case ($urandom_range(0, 3))
                    0: begin cfg[r] = 32'h8000_0000; cfg[r+1] = 32'h7fff_ffff; end
                    1: begin cfg[r] = a; cfg[r+1] = b; end
                    default: begin
                        if ($signed(a) > $signed(b)) begin cfg[r] = b; cfg[r+1] = a; end
                        else begin cfg[r] = a; cfg[r+1] = b; end
                    end
                endcase
            end
            write_regs(cfg);
            burst = 0;
            for (int n = 0; n < 200; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 30);
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst--;
                c = ($urandom_range(0, 99) < 4);
                err = pick_error();
                case ($urandom_range(0, 24))
                    0: dt = 24'h0;
                    1, 2, 3: dt = 24'($urandom_range(1, 255));
                    4: dt = 24'hff_ffff;
                    default: dt = 24'($urandom());
                endcase
                offer(c, err, dt);
                drive_q.push_back(next_drive(c, err, dt));
            end
            i_in_valid <= 1'b0;
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // Receiver stall: changing modes, plus one long hold-off to back the block up.
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (pressure_armed && n_results == 300) begin
            pressure_armed <= 1'b0;
            hold_cycles    <= 3000;
            i_out_stall    <= 1'b1;
        end else begin
            case ((n_results / 40) % 3)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Compare each accepted drive word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results <= n_results + 1;
            if (drive_q.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < 10) $display("unexpected drive word %h", o_drive_out);
            end else begin
                if (o_drive_out !== drive_q[0]) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("drive mismatch: expected %h, got %h", drive_q[0], o_drive_out);
                end
                void'(drive_q.pop_front());
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #40ms;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
design/pidda_pkg.sv
design/pidda_mul.sv
design/pidda_div.sv
design/pid_controller_deadband_antiwindup.sv
tb/pid_controller_deadband_antiwindup_tb.sv
